### src/dmpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dmpf_pkg;

	// field widths
	localparam int CNT_W   = 10;
	localparam int SPEED_W = 11;
	localparam int GAIN_W  = 7;
	localparam int TGT_W   = 8;
	localparam int ERR_W   = 12;
	localparam int D1_W    = 13;
	localparam int D2_W    = 14;
	localparam int FFN_W   = 13;
	localparam int FFQ_W   = 10;
	localparam int PP_W    = 21;
	localparam int IP_W    = 20;
	localparam int DP_W    = 22;
	localparam int SUM_W   = 23;
	localparam int DRV_W   = 25;
	localparam int DUTY_W  = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// feedforward (|t|*88+37)/10, the divide done by reciprocal 6554/2^16
	localparam int FF_MUL   = 88;
	localparam int FF_ADD   = 37;
	localparam int FF_LO    = 7;
	localparam int FF_HI    = 80;
	localparam int FF_RECIP = 6554;
	localparam int FF_SHIFT = 16;
	localparam int FFP_W    = FFN_W + FFN_W;

	localparam int DRIVE_SCALE = 10;
	localparam int DRIVE_LIMIT = 10000;
	localparam int DUTY_CAP    = 9000;
	// limits seen before the x10 scaling
	localparam int SUM_LIMIT   = DRIVE_LIMIT / DRIVE_SCALE;
	localparam int SUM_REV_CAP = DUTY_CAP / DRIVE_SCALE;

	localparam int PROP_RST  = 11;
	localparam int INTEG_RST = 7;
	localparam int DERIV_RST = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP   = 3'd0,
		CFG_INTEG  = 3'd1,
		CFG_DERIV  = 3'd2,
		CFG_TGT_L  = 3'd3,
		CFG_TGT_R  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} gains_t;

	typedef struct packed {
		logic               side;
		logic [SPEED_W-1:0] speed;
		logic [ERR_W-1:0]   e0;
		logic [D1_W-1:0]    d1;
		logic [D2_W-1:0]    d2;
		logic [FFN_W-1:0]   ffnum;
		logic               ff_neg;
		logic               blk;
	} err_word_t;

	typedef struct packed {
		logic               side;
		logic [SPEED_W-1:0] speed;
		logic [SUM_W-1:0]   sum;
		logic               blk;
	} sum_word_t;

endpackage
`default_nettype wire

### src/dmpf_err.sv
`timescale 1ns / 1ps
`default_nettype none
module dmpf_err (
	input  wire                            clk,
	input  wire                            arst_n,
	input  dmpf_pkg::pipe_en_t             en,
	input  wire [dmpf_pkg::CNT_W-1:0]      pulse_count,
	input  wire                            direction_pin,
	input  wire [dmpf_pkg::TGT_W-1:0]      target_left,
	input  wire [dmpf_pkg::TGT_W-1:0]      target_right,
	output dmpf_pkg::err_word_t            err_s1
);
	import dmpf_pkg::*;

	logic               side_q;
	logic [ERR_W-1:0]   prev_q  [2];
	logic [ERR_W-1:0]   older_q [2];

	logic               fwd;
	logic [SPEED_W-1:0] cnt_ext;
	logic [SPEED_W-1:0] speed;
	logic signed [TGT_W-1:0] tgt;
	logic [TGT_W-1:0]   t_mag;
	logic               ff_en;
	logic [ERR_W-1:0]   e0, e1, e2;
	err_word_t          w;

	always_comb begin
		// right side encoder counts the other way
		fwd     = side_q ? ~direction_pin : direction_pin;
		cnt_ext = {1'b0, pulse_count};
		speed   = fwd ? cnt_ext : (~cnt_ext + 1'b1);
		tgt     = side_q ? target_right : target_left;
		t_mag   = tgt[TGT_W-1] ? (~tgt + 1'b1) : tgt;
		ff_en   = (t_mag >= TGT_W'(FF_LO)) && (t_mag <= TGT_W'(FF_HI));
		e1      = prev_q[side_q];
		e2      = older_q[side_q];
		e0      = {{(ERR_W-TGT_W){tgt[TGT_W-1]}}, tgt}
		        - {{(ERR_W-SPEED_W){speed[SPEED_W-1]}}, speed};

		w.side   = side_q;
		w.speed  = speed;
		w.e0     = e0;
		w.d1     = {e0[ERR_W-1], e0} - {e1[ERR_W-1], e1};
		w.d2     = {{2{e0[ERR_W-1]}}, e0} - {e1[ERR_W-1], e1, 1'b0}
		         + {{2{e2[ERR_W-1]}}, e2};
		w.ffnum  = ff_en ? (FFN_W'(t_mag) * FFN_W'(FF_MUL) + FFN_W'(FF_ADD)) : '0;
		w.ff_neg = tgt[TGT_W-1];
		w.blk    = (tgt >= TGT_W'(FF_LO));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= 1'b0;
			prev_q[0]  <= '0;
			prev_q[1]  <= '0;
			older_q[0] <= '0;
			older_q[1] <= '0;
		end else if (en.accept) begin
			side_q          <= ~side_q;
			prev_q[side_q]  <= e0;
			older_q[side_q] <= e1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			err_s1 <= w;
		end
	end

endmodule
`default_nettype wire

### src/dmpf_sum.sv
`timescale 1ns / 1ps
`default_nettype none
module dmpf_sum (
	input  wire                  clk,
	input  dmpf_pkg::pipe_en_t   en,
	input  dmpf_pkg::gains_t     gains,
	input  dmpf_pkg::err_word_t  err_s1,
	output dmpf_pkg::sum_word_t  sum_word
);
	import dmpf_pkg::*;

	logic signed [PP_W-1:0] pp, pp_s2;
	logic signed [IP_W-1:0] ip, ip_s2;
	logic signed [DP_W-1:0] dp, dp_s2;
	logic [FFP_W-1:0]       ffp;
	logic [FFQ_W-1:0]       ffq_s2;
	logic                   ff_neg_s2, side_s2, blk_s2;
	logic [SPEED_W-1:0]     speed_s2;
	logic [SUM_W-1:0]       ff_term;

	always_comb begin
		pp  = $signed({1'b0, gains.prop})  * $signed(err_s1.d1);
		ip  = $signed({1'b0, gains.integ}) * $signed(err_s1.e0);
		dp  = $signed({1'b0, gains.deriv}) * $signed(err_s1.d2);
		ffp = FFP_W'(err_s1.ffnum) * FFP_W'(FF_RECIP);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pp_s2     <= pp;
			ip_s2     <= ip;
			dp_s2     <= dp;
			ffq_s2    <= ffp[FF_SHIFT +: FFQ_W];
			ff_neg_s2 <= err_s1.ff_neg;
			side_s2   <= err_s1.side;
			speed_s2  <= err_s1.speed;
			blk_s2    <= err_s1.blk;
		end
	end

	// sum feeds the duty mapper in the same cycle
	always_comb begin
		ff_term        = ff_neg_s2 ? (~SUM_W'(ffq_s2) + 1'b1) : SUM_W'(ffq_s2);
		sum_word.side  = side_s2;
		sum_word.speed = speed_s2;
		sum_word.blk   = blk_s2;
		sum_word.sum   = {{(SUM_W-PP_W){pp_s2[PP_W-1]}}, pp_s2}
		               + {{(SUM_W-IP_W){ip_s2[IP_W-1]}}, ip_s2}
		               + {{(SUM_W-DP_W){dp_s2[DP_W-1]}}, dp_s2}
		               + ff_term;
	end

endmodule
`default_nettype wire

### src/dmpf_duty.sv
`timescale 1ns / 1ps
`default_nettype none
module dmpf_duty (
	input  wire                               clk,
	input  dmpf_pkg::pipe_en_t                en,
	input  dmpf_pkg::sum_word_t               sum_word,
	output logic                              side,
	output logic [dmpf_pkg::DUTY_W-1:0]       forward_duty,
	output logic [dmpf_pkg::DUTY_W-1:0]       reverse_duty,
	output logic signed [dmpf_pkg::DRV_W-1:0] drive_value,
	output logic signed [dmpf_pkg::SPEED_W-1:0] measured_speed
);
	import dmpf_pkg::*;

	localparam int DX_W = SUM_W + 4;

	logic signed [SUM_W-1:0] s;
	logic [DX_W-1:0]         drv;
	logic [DX_W-1:0]         drv_neg;
	logic [DUTY_W-1:0]       fd, rd;

	always_comb begin
		s       = $signed(sum_word.sum);
		drv     = {{(DX_W-SUM_W){s[SUM_W-1]}}, s} * DX_W'(DRIVE_SCALE);
		drv_neg = ~drv + 1'b1;
		fd      = '0;
		rd      = '0;
		// compares run on the unscaled sum
		priority if (s >= SUM_W'(SUM_LIMIT)) begin
			fd = DUTY_W'(DUTY_CAP);
		end else if (s < 0 && sum_word.blk) begin
			// reverse blocked while target points forward
		end else if (s < 0) begin
			rd = (s < -SUM_W'(SUM_REV_CAP)) ? DUTY_W'(DUTY_CAP) : drv_neg[DUTY_W-1:0];
		end else begin
			fd = drv[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			side           <= sum_word.side;
			forward_duty   <= fd;
			reverse_duty   <= rd;
			drive_value    <= drv[DRV_W-1:0];
			measured_speed <= sum_word.speed;
		end
	end

endmodule
`default_nettype wire

### src/dual_motor_pid_feedforward.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-motor incremental PID speed loop with target feedforward.
// Input channel (in_valid/in_ready): one word per encoder tick, holding
// pulse_count and direction_pin. Words alternate left, right, left...;
// the side of each result is reported on the side output.
// Output channel (out_valid/out_ready): one result word per input word,
// in order: duties, raw drive value and the signed measured speed.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): gains and the
// two targets, always ready; indexes past the target registers are dropped.
// Write config only while no word is in flight.
// Pipeline: error register, product register, then sum, x10 scaling and
// duty mapping into the output register, where out_valid rises.
// Throughput: one word per cycle unless out_ready stalls; the three gain
// multipliers and the feedforward reciprocal multiply share one stage.
// Reset: left side first, error history zero, gains 11/7/1, targets 0.
// Stall: when out_ready is low, stages fill behind the output register and
// in_ready drops only once every stage holds a word.
module dual_motor_pid_feedforward (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [dmpf_pkg::CNT_W-1:0]          pulse_count,
	input  wire                                direction_pin,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               side,
	output logic [dmpf_pkg::DUTY_W-1:0]        forward_duty,
	output logic [dmpf_pkg::DUTY_W-1:0]        reverse_duty,
	output logic signed [dmpf_pkg::DRV_W-1:0]  drive_value,
	output logic signed [dmpf_pkg::SPEED_W-1:0] measured_speed,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [dmpf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [dmpf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dmpf_pkg::*;

	// config registers
	gains_t            gains_q;
	logic [TGT_W-1:0]  tgt_l_q;
	logic [TGT_W-1:0]  tgt_r_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop  <= GAIN_W'(PROP_RST);
			gains_q.integ <= GAIN_W'(INTEG_RST);
			gains_q.deriv <= GAIN_W'(DERIV_RST);
			tgt_l_q       <= '0;
			tgt_r_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PROP:  gains_q.prop  <= cfg_data[GAIN_W-1:0];
				CFG_INTEG: gains_q.integ <= cfg_data[GAIN_W-1:0];
				CFG_DERIV: gains_q.deriv <= cfg_data[GAIN_W-1:0];
				CFG_TGT_L: tgt_l_q       <= cfg_data[TGT_W-1:0];
				CFG_TGT_R: tgt_r_q       <= cfg_data[TGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline occupancy; each stage moves when the one after it has room
	logic     v_s1, v_s2;
	logic     rdy_s1, rdy_s2, rdy_s3;
	pipe_en_t en;

	always_comb begin
		rdy_s3    = ~out_valid | out_ready;
		rdy_s2    = ~v_s2 | rdy_s3;
		rdy_s1    = ~v_s1 | rdy_s2;
		in_ready  = rdy_s1;
		en.accept = in_valid & rdy_s1;
		en.s1     = rdy_s1;
		en.s2     = rdy_s2;
		en.s3     = rdy_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) out_valid <= v_s2;
		end
	end

	err_word_t err_s1;
	sum_word_t sum_word;

	// speed, error and its differences; owns side toggle and error history
	dmpf_err u_err (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.pulse_count   (pulse_count),
		.direction_pin (direction_pin),
		.target_left   (tgt_l_q),
		.target_right  (tgt_r_q),
		.err_s1        (err_s1)
	);

	// gain products and feedforward registered, then their sum
	dmpf_sum u_sum (
		.clk      (clk),
		.en       (en),
		.gains    (gains_q),
		.err_s1   (err_s1),
		.sum_word (sum_word)
	);

	// x10 scaling and forward / reverse duty mapping, output register
	dmpf_duty u_duty (
		.clk            (clk),
		.en             (en),
		.sum_word       (sum_word),
		.side           (side),
		.forward_duty   (forward_duty),
		.reverse_duty   (reverse_duty),
		.drive_value    (drive_value),
		.measured_speed (measured_speed)
	);

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import dmpf_pkg::*;

	// input accept to out_valid
	localparam int PIPE_LAT = 2;
	// first register index that the block has to drop
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(CFG_TGT_R + 1);

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	// one expected output word
	typedef struct packed {
		logic                      side;
		logic [DUTY_W-1:0]         fwd;
		logic [DUTY_W-1:0]         rev;
		logic signed [DRV_W-1:0]   drive;
		logic signed [SPEED_W-1:0] speed;
	} duty_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CNT_W-1:0] pulse_count = '0;
	logic direction_pin = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic side;
	logic [DUTY_W-1:0] forward_duty;
	logic [DUTY_W-1:0] reverse_duty;
	logic signed [DRV_W-1:0] drive_value;
	logic signed [SPEED_W-1:0] measured_speed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dual_motor_pid_feedforward u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pulse_count    (pulse_count),
		.direction_pin  (direction_pin),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.side           (side),
		.forward_duty   (forward_duty),
		.reverse_duty   (reverse_duty),
		.drive_value    (drive_value),
		.measured_speed (measured_speed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: own copy of the registers and the error history.
	// Updated at edges where the block accepts a register write or a word.
	// ---------------------------------------------------------------
	logic [GAIN_W-1:0] kp = GAIN_W'(PROP_RST);
	logic [GAIN_W-1:0] ki = GAIN_W'(INTEG_RST);
	logic [GAIN_W-1:0] kd = GAIN_W'(DERIV_RST);
	logic signed [TGT_W-1:0] tgt_l = '0;
	logic signed [TGT_W-1:0] tgt_r = '0;
	logic mdl_side = 1'b0;                      // left goes first
	logic signed [ERR_W-1:0] err_prev [2] = '{'0, '0};
	logic signed [ERR_W-1:0] err_old [2] = '{'0, '0};

	duty_word_t duty_q[$];                      // words still owed by the block
	int err_cnt = 0;
	int words_sent = 0;
	int words_checked = 0;

	// stimulus side bookkeeping
	logic tx_side = 1'b0;                       // side of the next word we offer
	int set_tgt_l = 0;                          // targets as last written
	int set_tgt_r = 0;
	int burst_left = 0;
	logic gaps_on = 1'b1;

	// receiver pacing
	int hold_req = 0;
	int hold_left = 0;
	int mode_left = 0;
	int rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;

	// (|t|*88 + 37)/10 with the sign of t, only for 7 <= |t| <= 80
	function automatic int feedfwd(input int t);
		if (t >= FF_LO && t <= FF_HI)
			return (t * FF_MUL + FF_ADD) / DRIVE_SCALE;
		if (t <= -FF_LO && t >= -FF_HI)
			return -(((-t) * FF_MUL + FF_ADD) / DRIVE_SCALE);
		return 0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_PROP:  kp = d[GAIN_W-1:0];
			CFG_INTEG: ki = d[GAIN_W-1:0];
			CFG_DERIV: kd = d[GAIN_W-1:0];
			CFG_TGT_L: tgt_l = d;
			CFG_TGT_R: tgt_r = d;
			default:   ;                        // spare index, dropped
		endcase
	endfunction

	// Works out the output word for one tick and advances the side's history.
	function automatic duty_word_t predict_duty(input logic [CNT_W-1:0] cnt,
			input logic dir);
		duty_word_t w;
		int spd, tgt, e0, e1, e2, drv, fd, rd;
		logic s, fwd;
		s = mdl_side;
		// right encoder is mounted mirrored: pin low means forward there
		fwd = s ? !dir : dir;
		spd = fwd ? int'(cnt) : -int'(cnt);
		tgt = s ? int'(tgt_r) : int'(tgt_l);
		e0 = tgt - spd;
		e1 = int'(err_prev[s]);
		e2 = int'(err_old[s]);
		drv = (int'(kp) * (e0 - e1) + int'(ki) * e0 + int'(kd) * (e0 - 2 * e1 + e2)
			+ feedfwd(tgt)) * DRIVE_SCALE;
		fd = 0;
		rd = 0;
		if (drv >= DRIVE_LIMIT) begin
			fd = DUTY_CAP;
		end else if (drv < 0 && tgt >= FF_LO) begin
			// forward target: reverse drive is blocked, both duties stay 0
		end else if (drv < 0) begin
			rd = (-drv > DUTY_CAP) ? DUTY_CAP : -drv;
		end else begin
			fd = drv;
		end
		err_old[s] = ERR_W'(e1);
		err_prev[s] = ERR_W'(e0);
		mdl_side = !mdl_side;
		w.side = s;
		w.fwd = DUTY_W'(fd);
		w.rev = DUTY_W'(rd);
		w.drive = DRV_W'(drv);
		w.speed = SPEED_W'(spd);
		return w;
	endfunction

	// Register writes and accepted input words feed the predictor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				duty_q.push_back(predict_duty(pulse_count, direction_pin));
		end
	end

	function automatic void check_field(input string name, input logic signed [31:0] expv,
			input logic signed [31:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			err_cnt++;
		end
	endfunction

	// Every accepted output word is compared with the oldest prediction.
	always @(posedge clk) begin : chk_out
		duty_word_t want;
		if (arst_n && out_valid && out_ready) begin
			words_checked++;
			if (duty_q.size() == 0) begin
				$error("output word with nothing expected");
				err_cnt++;
			end else begin
				want = duty_q.pop_front();
				check_field("side", 32'(want.side), 32'(side));
				check_field("forward_duty", 32'(want.fwd), 32'(forward_duty));
				check_field("reverse_duty", 32'(want.rev), 32'(reverse_duty));
				check_field("drive_value", 32'(want.drive), 32'(drive_value));
				check_field("measured_speed", 32'(want.speed), 32'(measured_speed));
			end
		end
	end

	// Receiver: changes its pacing every so often; a long hold-off can be
	// requested, and is counted down here.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
				default:   out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Offer one tick word; bursts of random length, random gaps between if gaps_on.
	task automatic send_tick(input logic [CNT_W-1:0] cnt, input logic dir);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pulse_count <= cnt;
		direction_pin <= dir;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		tx_side = !tx_side;
	endtask

	// cfg_valid is left high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [7:0] gp, input logic [7:0] gi,
			input logic [7:0] gd, input logic [7:0] tl, input logic [7:0] tr);
		write_reg(CFG_PROP, gp);
		write_reg(CFG_INTEG, gi);
		write_reg(CFG_DERIV, gd);
		write_reg(CFG_TGT_L, tl);
		write_reg(CFG_TGT_R, tr);
		cfg_valid <= 1'b0;
		set_tgt_l = $signed(tl);
		set_tgt_r = $signed(tr);
	endtask

	// Stop offering and wait until every word sent has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (words_checked != words_sent) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// Mostly speeds near the current target (keeps the loop in its linear
	// range, hits forward/reverse mapping); the rest anything at all.
	task automatic send_mixed(input int n, input int wild_pct);
		int k, spd, tgt;
		logic [CNT_W-1:0] cnt;
		logic dir, fwd;
		for (k = 0; k < n; k++) begin
			tgt = tx_side ? set_tgt_r : set_tgt_l;
			if ($urandom_range(0, 99) < wild_pct) begin
				cnt = CNT_W'($urandom);
				if ($urandom_range(0, 7) == 0)
					cnt = $urandom_range(0, 1) ? '1 : '0;
				dir = 1'($urandom);
			end else begin
				spd = tgt + int'($urandom_range(0, 40)) - 20;
				if (spd > 1023)
					spd = 1023;
				if (spd < -1023)
					spd = -1023;
				fwd = (spd >= 0);
				cnt = fwd ? CNT_W'(spd) : CNT_W'(-spd);
				dir = tx_side ? !fwd : fwd;
			end
			send_tick(cnt, dir);
		end
	endtask

	function automatic logic [7:0] pick_gain();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'h7F;
			default: return 8'($urandom);       // bit 7 random, must be ignored
		endcase
	endfunction

	// feedforward window edges, blocking edge and the 8-bit extremes
	int tgt_marks [12] = '{-128, -81, -80, -8, -7, -6, 0, 6, 7, 80, 81, 127};

	function automatic logic [7:0] pick_target();
		case ($urandom_range(0, 2))
			0:       return 8'(tgt_marks[$urandom_range(0, 11)]);
			1:       return 8'($urandom);
			default: return 8'(int'($urandom_range(0, 160)) - 80);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset gains and zero targets; count and pin extremes on both sides.
	task automatic test_reset_values();
		send_tick('1, 1'b1);                    // left forward, full count
		send_tick('1, 1'b1);                    // right reverse, full count
		send_tick('1, 1'b0);                    // left reverse
		send_tick('0, 1'b0);                    // right, zero count
		wait_idle();
	endtask

	// Spare register indexes are dropped; data bits above a field are ignored.
	task automatic test_reg_writes();
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, (1 << CFG_IDX_W) - 1)),
			8'hFF);
		set_config(8'hFF, 8'h85, 8'h83, 8'h80, 8'h7F);
		send_tick(10'd512, 1'b1);
		send_tick(10'd1, 1'b0);
		wait_idle();
	endtask

	// Pure error gain of 1 so each duty mapping case is easy to aim at.
	task automatic test_duty_map();
		// gains 0/1/0 written with bit 7 set; targets +50 / -50
		set_config(8'h80, 8'h81, 8'h80, 8'd50, 8'hCE);
		send_tick(10'd50, 1'b1);                // left on target: forward duty
		send_tick(10'd0, 1'b0);                 // right stopped: reverse duty
		send_tick('1, 1'b1);                    // left overspeed: reverse blocked
		send_tick('1, 1'b1);                    // right far reverse: forward
		send_tick('1, 1'b0);                    // left backward: large drive
		send_tick('1, 1'b0);                    // right far forward: reverse capped
		wait_idle();
		// left target 0 puts drive exactly on the limit; right target at the
		// lowest value that still blocks reverse
		set_config(8'h00, 8'h01, 8'h00, 8'd0, 8'd7);
		send_tick(10'd1000, 1'b0);              // drive 10000
		send_tick(10'd200, 1'b0);               // negative drive, blocked
		send_tick(10'd999, 1'b0);               // drive 9990, just below
		send_tick(10'd0, 1'b1);                 // small positive drive
		wait_idle();
	endtask

	// Configuration changes between phases of random ticks.
	task automatic test_random_phases();
		int ph;
		for (ph = 0; ph < 11; ph++) begin
			wait_idle();
			if (ph == 0)
				set_config(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h80);  // widest drive
			else if (ph == 1)
				set_config(8'h00, 8'h00, 8'h00, 8'd80, -8'sd80);
			else begin
				if ($urandom_range(0, 3) == 0)
					write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST,
						(1 << CFG_IDX_W) - 1)), 8'($urandom));
				set_config(pick_gain(), pick_gain(), pick_gain(), pick_target(),
					pick_target());
			end
			gaps_on = ($urandom_range(0, 9) < 7);
			send_mixed(150, 25);
		end
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// Receiver holds off while ticks keep coming, so the pipe fills and
	// in_ready has to drop.
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req = 80;
		send_mixed(40, 30);
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// Sender stops until every word is back, then carries on with the same
	// history.
	task automatic test_drain_pause();
		send_mixed(15, 20);
		wait_idle();
		send_mixed(15, 20);
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_reg_writes();
		test_duty_map();
		test_backpressure();
		test_random_phases();
		test_drain_pause();
		wait_idle();
		if (duty_q.size() != 0) begin
			$error("%0d expected words never came out", duty_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### dual_motor_pid_feedforward.f
src/dmpf_pkg.sv
src/dmpf_err.sv
src/dmpf_sum.sv
src/dmpf_duty.sv
src/dual_motor_pid_feedforward.sv
tb/tb.sv
